>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg)
`define ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/cbwpl_pkg.sv
// Package for the color box window peak locator.
// Register indexes, widths and result type; no dependencies.
package cbwpl_pkg;
  localparam int unsigned NumClasses = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RED_BOX    = 3'd0,
    REG_YELLOW_BOX = 3'd1,
    REG_WHITE_BOX  = 3'd2,
    REG_WIDTH      = 3'd3,
    REG_HEIGHT     = 3'd4,
    REG_BALL_SIZE  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [9:0] red_x;
    logic [9:0] red_y;
    logic [8:0] red_score;
    logic [9:0] yellow_x;
    logic [9:0] yellow_y;
    logic [8:0] yellow_score;
    logic [9:0] white_x;
    logic [9:0] white_y;
    logic [8:0] white_score;
  } result_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  function automatic logic in_box(logic [47:0] box, pixel_t p);
    in_box = p.red >= box[47:40] && p.red <= box[39:32] &&
             p.green >= box[31:24] && p.green <= box[23:16] &&
             p.blue >= box[15:8] && p.blue <= box[7:0];
  endfunction
endpackage

>>> hdl/cbwpl_if.sv
// Valid/ready stream and configuration interfaces.
// Depends on cbwpl_pkg.
interface cbwpl_pix_if;
  logic valid;
  logic ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface cbwpl_res_if;
  logic valid;
  logic ready;
  logic [9:0] red_x;
  logic [9:0] red_y;
  logic [8:0] red_score;
  logic [9:0] yellow_x;
  logic [9:0] yellow_y;
  logic [8:0] yellow_score;
  logic [9:0] white_x;
  logic [9:0] white_y;
  logic [8:0] white_score;
  modport source (output valid, red_x, red_y, red_score, yellow_x, yellow_y,
                  yellow_score, white_x, white_y, white_score, input ready);
  modport sink (input valid, red_x, red_y, red_score, yellow_x, yellow_y,
                yellow_score, white_x, white_y, white_score, output ready);
endinterface

interface cbwpl_cfg_if;
  logic valid;
  logic ready;
  logic [cbwpl_pkg::CfgIdxW-1:0] index;
  logic [cbwpl_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/cbwpl_colmem.sv
// Column-count memory for read-modify-write, with a registered read port.
// Self-contained; used by the top level.
module cbwpl_colmem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned DataW = 15
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [DataW-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [DataW-1:0]         wr_data_i
);
  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end
endmodule

>>> hdl/color_box_window_peak_locator.sv
// Top level of the color box window peak locator.
// Depends on cbwpl_pkg, cbwpl_if, cbwpl_colmem and assert_macros.svh.
//
// Usage: pixels enter on pix in raster order, one beat per pixel. Each is
// classified against the red, yellow and white boxes. A window of ball_size
// by ball_size pixels is summed by per-column counts held in a memory
// (running vertical sums) and a horizontal sliding sum over the last
// ball_size column counts. Class history rows sit in a second memory.
// After the last pixel of a frame one result beat appears on res with the
// best window centre and count per class; the frame state then clears.
// Throughput: one pixel per cycle, unless a frame end is held while the
// result register is busy. res.valid rises when the last pixel's beat has
// passed stage 1 into the result register (memory read and compare share stage 1).
// A result waits in an output register; while the sink stalls, pixels are
// still taken until another frame end would need that register.
// Reset clears counters, best windows and registers to their defaults; the
// memories need no clearing since every read entry is written earlier in
// the frame. cfg is always ready; write it only with no pixel in flight.
module color_box_window_peak_locator #(
  parameter int unsigned MaxWidth  = 1024,
  parameter int unsigned MaxHeight = 1024,
  parameter int unsigned MaxWindow = 20
) (
  input  logic clk_i,
  input  logic rst_ni,
  cbwpl_pix_if.sink   pix,
  cbwpl_cfg_if.sink   cfg,
  cbwpl_res_if.source res
);
  `include "assert_macros.svh"

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned RowW = $clog2(MaxHeight);
  localparam int unsigned WinW = $clog2(MaxWindow + 1);
  localparam int unsigned SlotW = $clog2(MaxWindow);
  localparam int unsigned CntW = $clog2(MaxWindow * MaxWindow + 1);
  localparam int unsigned VW = $clog2(MaxWindow + 1);
  localparam int unsigned HistD = MaxWindow * MaxWidth;
  localparam int unsigned HistAW = $clog2(HistD);

  logic [47:0] box_q [3];
  logic [10:0] width_q, height_q;
  logic [4:0] bs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q[0] <= '0;
      box_q[1] <= '0;
      box_q[2] <= '0;
      width_q <= 11'd640;
      height_q <= 11'd480;
      bs_q <= 5'd10;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        cbwpl_pkg::REG_RED_BOX:    box_q[0] <= cfg.data;
        cbwpl_pkg::REG_YELLOW_BOX: box_q[1] <= cfg.data;
        cbwpl_pkg::REG_WHITE_BOX:  box_q[2] <= cfg.data;
        cbwpl_pkg::REG_WIDTH:      width_q <= cfg.data[10:0];
        cbwpl_pkg::REG_HEIGHT:     height_q <= cfg.data[10:0];
        cbwpl_pkg::REG_BALL_SIZE:  bs_q <= cfg.data[4:0];
        default: ;
      endcase
    end
  end
  assign cfg.ready = 1'b1;

  // clamped sizes
  logic [12:0] w_c, h_c;
  logic [WinW-1:0] bs_c;
  always_comb begin
    w_c = (width_q == 11'd0) ? 13'd1 :
          (13'(width_q) > 13'(MaxWidth)) ? 13'(MaxWidth) : 13'(width_q);
    h_c = (height_q == 11'd0) ? 13'd1 :
          (13'(height_q) > 13'(MaxHeight)) ? 13'(MaxHeight) : 13'(height_q);
    bs_c = (bs_q == 5'd0) ? WinW'(1) :
           (32'(bs_q) > MaxWindow) ? WinW'(MaxWindow) : WinW'(bs_q);
  end

  // stage 0: accept, classify, position
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [SlotW-1:0] slot_q;
  logic accept;
  logic res_busy;
  logic last_col, last_pix;

  assign last_col = (13'(col_q) + 13'd1) >= w_c;
  assign last_pix = last_col && ((13'(row_q) + 13'd1) >= h_c);
  // hold input only when a frame end would collide with a full result register
  assign pix.ready = !(res_busy && last_pix);
  assign accept = pix.valid && pix.ready;

  cbwpl_pkg::pixel_t px;
  logic [2:0] cls;
  always_comb begin
    px = '{red: pix.red, green: pix.green, blue: pix.blue};
    for (int c = 0; c < 3; c++) begin
      cls[c] = cbwpl_pkg::in_box(box_q[c], px);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      slot_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        if (last_pix) begin
          row_q <= '0;
          slot_q <= '0;
        end else begin
          row_q <= row_q + RowW'(1);
          slot_q <= (32'(slot_q) == MaxWindow - 1) ? '0 : slot_q + SlotW'(1);
        end
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  // history memory: class bits of last MaxWindow rows
  logic [2:0] hist [HistD];
  logic [2:0] old_cls_q;
  logic [SlotW-1:0] old_slot;
  logic [HistAW-1:0] hist_wa, hist_ra;
  logic drop_old;
  always_comb begin
    old_slot = (32'(slot_q) >= 32'(bs_c)) ? SlotW'(32'(slot_q) - 32'(bs_c))
                                         : SlotW'(32'(slot_q) + MaxWindow - 32'(bs_c));
    hist_wa = HistAW'(32'(slot_q) * MaxWidth + 32'(col_q));
    hist_ra = HistAW'(32'(old_slot) * MaxWidth + 32'(col_q));
    drop_old = 32'(row_q) >= 32'(bs_c);
  end
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist[hist_wa] <= cls;
      old_cls_q <= hist[hist_ra];
    end
  end

  // stage 1 registers
  logic s1_v_q, s1_first_row_q, s1_drop_q, s1_last_q, s1_in_q;
  logic s1_xok_q;
  logic [2:0] s1_cls_q;
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;
  logic [WinW-1:0] s1_bs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
    end
  end
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_first_row_q <= row_q == '0;
      s1_drop_q <= drop_old;
      s1_last_q <= last_pix;
      s1_in_q <= (13'(col_q) < w_c) && (13'(row_q) < h_c) &&
                 (32'(row_q) + 1 >= 32'(bs_c));
      s1_xok_q <= 32'(col_q) + 1 >= 32'(bs_c);
      s1_cls_q <= cls;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
      s1_bs_q <= bs_c;
    end
  end

  // column counts: 3 x VW bits per column
  logic [3*VW-1:0] colcnt_rd, colcnt_wr;
  logic [3*VW-1:0] colcnt_byp_q;
  logic [ColW-1:0] colcnt_wa_q;
  logic colcnt_we_q;
  cbwpl_colmem #(.Depth(MaxWidth), .DataW(3*VW)) u_colmem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (colcnt_rd),
    .wr_en_i   (s1_v_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (colcnt_wr)
  );
  // forward when the same column is read in the same cycle as it is written
  logic byp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (accept) begin
      byp_q <= s1_v_q && (s1_col_q == col_q);
    end
  end
  always_ff @(posedge clk_i) begin
    if (accept) begin
      colcnt_byp_q <= colcnt_wr;
    end
  end

  logic [VW-1:0] vnew [3];
  logic [3*VW-1:0] cur;
  always_comb begin
    cur = byp_q ? colcnt_byp_q : colcnt_rd;
    for (int c = 0; c < 3; c++) begin
      vnew[c] = s1_first_row_q ? VW'(s1_cls_q[c])
              : VW'(cur[c*VW +: VW] + VW'(s1_cls_q[c])
                    - VW'(s1_drop_q & old_cls_q[c]));
      colcnt_wr[c*VW +: VW] = vnew[c];
    end
  end

  // horizontal sliding sum via shift line of recent column counts
  logic [VW-1:0] recent_q [3][MaxWindow];
  logic [CntW-1:0] hsum [3];
  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      for (int c = 0; c < 3; c++) begin
        recent_q[c][0] <= vnew[c];
        for (int k = 1; k < MaxWindow; k++) begin
          recent_q[c][k] <= recent_q[c][k-1];
        end
      end
    end
  end
  logic [CntW-1:0] wsum_q [3];
  logic [VW-1:0] leave [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      leave[c] = '0;
      for (int k = 1; k <= MaxWindow; k++) begin
        if (32'(s1_bs_q) == k) leave[c] = recent_q[c][k-1];
      end
      if (s1_col_q == '0) begin
        hsum[c] = CntW'(vnew[c]);
      end else if (s1_xok_q && 32'(s1_col_q) + 1 > 32'(s1_bs_q)) begin
        hsum[c] = wsum_q[c] + CntW'(vnew[c]) - CntW'(leave[c]);
      end else begin
        hsum[c] = wsum_q[c] + CntW'(vnew[c]);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      for (int c = 0; c < 3; c++) begin
        wsum_q[c] <= hsum[c];
      end
    end
  end
  // when bs == 1 the window is just this column
  logic [CntW-1:0] score [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      score[c] = (s1_bs_q == WinW'(1)) ? CntW'(vnew[c]) : hsum[c];
    end
  end

  // best windows
  logic [8:0] best_s_q [3];
  logic [9:0] best_x_q [3], best_y_q [3];
  logic [8:0] sat [3];
  logic [9:0] cx, cy;
  always_comb begin
    cx = 10'(32'(s1_col_q) + 1 - 32'(s1_bs_q) + 32'(s1_bs_q >> 1));
    cy = 10'(32'(s1_row_q) + 1 - 32'(s1_bs_q) + 32'(s1_bs_q >> 1));
    for (int c = 0; c < 3; c++) begin
      sat[c] = (32'(score[c]) > 511) ? 9'd511 : 9'(score[c]);
    end
  end

  cbwpl_pkg::result_t res_q;
  logic res_v_q;
  logic [8:0] fs [3];
  logic [9:0] fx [3], fy [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      fs[c] = best_s_q[c];
      fx[c] = best_x_q[c];
      fy[c] = best_y_q[c];
      if (s1_in_q && s1_xok_q && sat[c] > best_s_q[c]) begin
        fs[c] = sat[c];
        fx[c] = cx;
        fy[c] = cy;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        best_s_q[c] <= '0;
        best_x_q[c] <= '0;
        best_y_q[c] <= '0;
      end
      res_v_q <= 1'b0;
    end else begin
      if (s1_v_q && s1_last_q) begin
        res_v_q <= 1'b1;
      end else if (res.valid && res.ready) begin
        res_v_q <= 1'b0;
      end
      if (s1_v_q) begin
        for (int c = 0; c < 3; c++) begin
          best_s_q[c] <= s1_last_q ? '0 : fs[c];
          best_x_q[c] <= s1_last_q ? '0 : fx[c];
          best_y_q[c] <= s1_last_q ? '0 : fy[c];
        end
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (s1_v_q && s1_last_q) begin
      res_q <= '{fx[0], fy[0], fs[0], fx[1], fy[1], fs[1], fx[2], fy[2], fs[2]};
    end
  end

  // a frame end in stage 1 needs the result register free
  logic pend_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= accept && last_pix;
    end
  end
  assign res_busy = (res_v_q && !res.ready) || pend_q;

  assign res.valid = res_v_q;
  assign res.red_x = res_q.red_x;
  assign res.red_y = res_q.red_y;
  assign res.red_score = res_q.red_score;
  assign res.yellow_x = res_q.yellow_x;
  assign res.yellow_y = res_q.yellow_y;
  assign res.yellow_score = res_q.yellow_score;
  assign res.white_x = res_q.white_x;
  assign res.white_y = res_q.white_y;
  assign res.white_score = res_q.white_score;

  `ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni,
    (s1_v_q && s1_last_q) |-> !(res_v_q && !res.ready), "result overwritten")
  `ASSERT_IMPL(a_pend_track, clk_i, rst_ni,
    pend_q |-> s1_last_q, "frame end tracking lost")
  `ASSERT_IMPL(a_hold_res, clk_i, rst_ni,
    (res.valid && !res.ready) |=> res.valid, "result dropped")
endmodule
